// ----- sv/gwbm_pkg.sv -----
// ============================================================================
// gwbm_pkg - shared types and constants for the grid wall border marker
// Tile codes, field widths, register indexes and the 3x3 marking function.
// ============================================================================
`default_nettype none

package gwbm_pkg;

    // tile codes
    localparam logic [1:0] TILE_UNSEEN = 2'd0;
    localparam logic [1:0] TILE_EMPTY  = 2'd1;
    localparam logic [1:0] TILE_WALL   = 2'd2;

    // field widths
    localparam int TILE_W = 2;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 10;

    // stream data widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - TILE_W - COL_W - ROW_W;

    // configuration port
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 11;
    localparam int GRID_WIDTH_BITS = 7;
    localparam int GRID_HEIGHT_BITS = 11;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    localparam int GRID_WIDTH_RST  = 64;
    localparam int GRID_HEIGHT_RST = 64;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 1024;

    // line store entry: upper row in the low bits, middle row above it
    localparam int LINE_W = 2 * TILE_W;

    // window: 3 columns of 6 bits, oldest column lowest
    localparam int WIN_W = 9 * TILE_W;

    localparam int NUM_SLOTS = 4;

    typedef struct packed {
        logic x_ge1;
        logic x_ge2;
        logic y_ge1;
        logic y_ge2;
        logic row_end;
        logic last_row;
    } pos_flags_t;

    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row_index;
        logic              last;
    } slot_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]  valid;
        slot_t [NUM_SLOTS-1:0] slot;
    } cand_t;

    // tile at window cell (wc, wr), turned into a wall when unseen and next
    // to an empty tile; the ok flags drop neighbors outside the grid
    function automatic logic [TILE_W-1:0] mark_tile(
        input logic [WIN_W-1:0] win,
        input int               wc,
        input int               wr,
        input logic             left_ok,
        input logic             right_ok,
        input logic             up_ok,
        input logic             down_ok
    );
        logic              hit;
        logic [TILE_W-1:0] centre;
        logic [TILE_W-1:0] nb;
        int                ic;
        int                ir;
        begin
            hit    = 1'b0;
            centre = win[(wc * 6 + wr * 2) +: 2];
            for (int dc = -1; dc <= 1; dc++)
            begin
                for (int dr = -1; dr <= 1; dr++)
                begin
                    ic = wc + dc;
                    ir = wr + dr;
                    if (!(dc == 0 && dr == 0)
                        && (dc != -1 || left_ok) && (dc != 1 || right_ok)
                        && (dr != -1 || up_ok) && (dr != 1 || down_ok)
                        && ic >= 0 && ic <= 2 && ir >= 0 && ir <= 2)
                    begin
                        nb = win[(ic * 6 + ir * 2) +: 2];
                        if (nb == TILE_EMPTY)
                        begin
                            hit = 1'b1;
                        end
                    end
                end
            end
            return (centre == TILE_UNSEEN && hit) ? TILE_WALL : centre;
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/grid_wall_border_marker.sv -----
// ============================================================================
// grid_wall_border_marker - wall marking on the border of explored tiles
// Streams a tile grid in raster order and turns unseen tiles next to empty
// tiles into walls, using two line stores and a 3x3 window.
// ============================================================================
// The block takes one 2-bit tile code per request in raster order and sends
// back the same grid in raster order, each tile tagged with its column and
// row; an unseen tile with an empty tile among its in-grid neighbors comes
// out as a wall, and tlast marks the final tile of the grid. Results trail
// the input by one row and one column: a tile at (x,y) releases the tile at
// (x-1,y-1), a row end also releases (width-1,y-1), and tiles of the last
// row come out interleaved with the row above, so the whole grid has left
// once its last tile is in and the bank has drained. An input tile is taken
// every cycle as long as the output keeps up; the output sends one result
// per cycle while m_axis_tready is high, so a row-end tile or a last-row
// tile gives up to two results and the final tile up to four, and the input
// waits while they go out. An accepted tile passes through the line store
// read and then the result bank. Both line stores share one RAM of MAX_WIDTH
// entries with one read and one write per cycle; they need no clearing after reset.
// Writing either grid register restarts at column 0, row 0 with an empty
// window; a size of 0 acts as 1 and one above the maximum as the maximum.
// Write the registers only while no tile is in flight.
// ============================================================================
`default_nettype none

module grid_wall_border_marker #(
    parameter int MAX_WIDTH  = gwbm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gwbm_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [gwbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [gwbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input tiles
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [gwbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [1:0] tile_in
    // result tiles
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [1:0] tile_out, [7:2] column, [17:8] row_index
    output logic [gwbm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                                     m_axis_tlast   // frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT);
    localparam int HH = $clog2(MAX_HEIGHT + 1);
    localparam int GWB = gwbm_pkg::GRID_WIDTH_BITS;
    localparam int GHB = gwbm_pkg::GRID_HEIGHT_BITS;
    localparam int RST_WIDTH  = (gwbm_pkg::GRID_WIDTH_RST > MAX_WIDTH) ?
                                MAX_WIDTH : gwbm_pkg::GRID_WIDTH_RST;
    localparam int RST_HEIGHT = (gwbm_pkg::GRID_HEIGHT_RST > MAX_HEIGHT) ?
                                MAX_HEIGHT : gwbm_pkg::GRID_HEIGHT_RST;

    // grid size registers, held already clamped
    logic [WW-1:0] width_reg;
    logic [WW-1:0] width_next;
    logic [HH-1:0] height_reg;
    logic [HH-1:0] height_next;
    logic          cfg_hit;

    // position of the next input tile
    logic [CW-1:0] x_reg;
    logic [CW-1:0] x_next;
    logic [CW-1:0] x_eff;
    logic [HW-1:0] y_reg;
    logic [HW-1:0] y_next;
    logic [HW-1:0] y_eff;

    gwbm_pkg::pos_flags_t flags;
    gwbm_pkg::cand_t      cand;
    logic                 accept;
    logic                 bank_free;
    logic                 cand_load;

    // ---------------------------------------------------------------- config
    assign cfg_hit = cfg_we && ((cfg_index == gwbm_pkg::REG_GRID_WIDTH)
                             || (cfg_index == gwbm_pkg::REG_GRID_HEIGHT));

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we && (cfg_index == gwbm_pkg::REG_GRID_WIDTH))
        begin
            if (cfg_data[GWB-1:0] == '0)
            begin
                width_next = WW'(1);
            end
            else if (int'(cfg_data[GWB-1:0]) > MAX_WIDTH)
            begin
                width_next = WW'(MAX_WIDTH);
            end
            else
            begin
                width_next = WW'(cfg_data[GWB-1:0]);
            end
        end
        if (cfg_we && (cfg_index == gwbm_pkg::REG_GRID_HEIGHT))
        begin
            if (cfg_data[GHB-1:0] == '0)
            begin
                height_next = HH'(1);
            end
            else if (int'(cfg_data[GHB-1:0]) > MAX_HEIGHT)
            begin
                height_next = HH'(MAX_HEIGHT);
            end
            else
            begin
                height_next = HH'(cfg_data[GHB-1:0]);
            end
        end
    end

    // -------------------------------------------------------- raster counter
    assign accept = s_axis_tvalid && s_axis_tready;

    // out-of-range positions wrap to the grid start
    assign x_eff = (WW'(x_reg) >= width_reg) ? '0 : x_reg;
    assign y_eff = (HH'(y_reg) >= height_reg) ? '0 : y_reg;

    always_comb
    begin
        flags.x_ge1    = (x_eff != '0);
        flags.x_ge2    = (x_eff > CW'(1));
        flags.y_ge1    = (y_eff != '0);
        flags.y_ge2    = (y_eff > HW'(1));
        flags.row_end  = (WW'(x_eff) == width_reg - WW'(1));
        flags.last_row = (HH'(y_eff) == height_reg - HH'(1));

        if (flags.row_end)
        begin
            x_next = '0;
            y_next = flags.last_row ? '0 : y_eff + HW'(1);
        end
        else
        begin
            x_next = x_eff + CW'(1);
            y_next = y_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(RST_WIDTH);
            height_reg <= HH'(RST_HEIGHT);
            x_reg      <= '0;
            y_reg      <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            if (cfg_hit)
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
            else if (accept)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
            end
        end
    end

    // ------------------------------------------------- window and line store
    gwbm_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_clear (cfg_hit),
        .in_valid  (accept),
        .in_tile   (s_axis_tdata[gwbm_pkg::TILE_W-1:0]),
        .in_x      (x_eff),
        .in_y      (y_eff),
        .in_flags  (flags),
        .bank_free (bank_free),
        .ready     (s_axis_tready),
        .cand_load (cand_load),
        .cand      (cand)
    );

    // ------------------------------------------------------- output results
    gwbm_result_bank u_bank (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (cand_load),
        .cand          (cand),
        .bank_free     (bank_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // the raster counter never leaves the configured grid
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(x_reg) < width_reg)
        else $error("column counter outside grid");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        HH'(y_reg) < height_reg)
        else $error("row counter outside grid");

endmodule

`default_nettype wire

// ----- sv/gwbm_ram.sv -----
// ============================================================================
// gwbm_ram - generic single write, single read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module gwbm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/gwbm_window.sv -----
// ============================================================================
// gwbm_window - line stores, 3x3 window and wall marking
// Holds one accepted tile while its line store entry is read, then shifts
// the window and forms the up to four results that the tile releases.
// ============================================================================
`default_nettype none

module gwbm_window #(
    parameter int MAX_WIDTH  = gwbm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gwbm_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_clear,
    input  wire logic                                in_valid,
    input  wire logic [gwbm_pkg::TILE_W-1:0]         in_tile,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]        in_x,
    input  wire logic [$clog2(MAX_HEIGHT)-1:0]       in_y,
    input  wire gwbm_pkg::pos_flags_t                in_flags,
    input  wire logic                                bank_free,
    output logic                                     ready,
    output logic                                     cand_load,
    output gwbm_pkg::cand_t                          cand
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int HW    = $clog2(MAX_HEIGHT);
    localparam int COL_W = gwbm_pkg::COL_W;
    localparam int ROW_W = gwbm_pkg::ROW_W;
    localparam int LW    = gwbm_pkg::LINE_W;
    localparam int TW    = gwbm_pkg::TILE_W;
    localparam int WW    = gwbm_pkg::WIN_W;

    logic                  b_valid_reg;
    logic [TW-1:0]         b_tile_reg;
    logic [CW-1:0]         b_x_reg;
    logic [HW-1:0]         b_y_reg;
    gwbm_pkg::pos_flags_t  b_flags_reg;
    logic                  byp_reg;
    logic [LW-1:0]         byp_data_reg;
    logic [WW-1:0]         win_reg;
    logic [WW-1:0]         win_next;
    logic [LW-1:0]         ram_rdata;
    logic [LW-1:0]         line;
    logic [LW-1:0]         wr_data;

    assign cand_load = b_valid_reg && bank_free;
    assign ready     = !b_valid_reg || bank_free;

    // rows above the current tile: upper in the low bits, middle above
    gwbm_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (cand_load),
        .waddr (b_x_reg),
        .wdata (wr_data),
        .re    (in_valid),
        .raddr (in_x),
        .rdata (ram_rdata)
    );

    // a one-column grid reads the entry written in the same cycle
    assign line     = byp_reg ? byp_data_reg : ram_rdata;
    assign wr_data  = {b_tile_reg, line[LW-1:TW]};
    assign win_next = {b_tile_reg, line, win_reg[WW-1:3*TW]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            if (in_valid)
            begin
                b_valid_reg <= 1'b1;
                byp_reg     <= cand_load && (b_x_reg == in_x);
            end
            else if (cand_load)
            begin
                b_valid_reg <= 1'b0;
            end
            if (cfg_clear)
            begin
                win_reg <= '0;
            end
            else if (cand_load)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            b_tile_reg   <= in_tile;
            b_x_reg      <= in_x;
            b_y_reg      <= in_y;
            b_flags_reg  <= in_flags;
            byp_data_reg <= wr_data;
        end
    end

    // slot order: (x-1,y-1), (x-1,y), (x,y-1), (x,y)
    always_comb
    begin
        cand.valid[0] = b_flags_reg.x_ge1 && b_flags_reg.y_ge1;
        cand.valid[1] = b_flags_reg.x_ge1 && b_flags_reg.last_row;
        cand.valid[2] = b_flags_reg.row_end && b_flags_reg.y_ge1;
        cand.valid[3] = b_flags_reg.row_end && b_flags_reg.last_row;

        cand.slot[0].tile = gwbm_pkg::mark_tile(win_next, 1, 1, b_flags_reg.x_ge2, 1'b1,
                                                b_flags_reg.y_ge2, 1'b1);
        cand.slot[1].tile = gwbm_pkg::mark_tile(win_next, 1, 2, b_flags_reg.x_ge2, 1'b1,
                                                b_flags_reg.y_ge1, 1'b0);
        cand.slot[2].tile = gwbm_pkg::mark_tile(win_next, 2, 1, b_flags_reg.x_ge1, 1'b0,
                                                b_flags_reg.y_ge2, 1'b1);
        cand.slot[3].tile = gwbm_pkg::mark_tile(win_next, 2, 2, b_flags_reg.x_ge1, 1'b0,
                                                b_flags_reg.y_ge1, 1'b0);

        cand.slot[0].column    = COL_W'(b_x_reg - CW'(1));
        cand.slot[0].row_index = ROW_W'(b_y_reg - HW'(1));
        cand.slot[0].last      = 1'b0;
        cand.slot[1].column    = COL_W'(b_x_reg - CW'(1));
        cand.slot[1].row_index = ROW_W'(b_y_reg);
        cand.slot[1].last      = 1'b0;
        cand.slot[2].column    = COL_W'(b_x_reg);
        cand.slot[2].row_index = ROW_W'(b_y_reg - HW'(1));
        cand.slot[2].last      = 1'b0;
        cand.slot[3].column    = COL_W'(b_x_reg);
        cand.slot[3].row_index = ROW_W'(b_y_reg);
        cand.slot[3].last      = 1'b1;
    end

    // a held tile keeps its position until the result bank takes it
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !bank_free) |=> (b_valid_reg && $stable(b_x_reg)))
        else $error("window stage dropped a held tile");

    // same-column back-to-back traffic must take the forwarded entry
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && cand_load && (in_x == b_x_reg)) |=> byp_reg)
        else $error("line store forwarding missed");

endmodule

`default_nettype wire

// ----- sv/gwbm_result_bank.sv -----
// ============================================================================
// gwbm_result_bank - result slots and output serializer
// Loads up to four results at once and sends them out one per cycle while m_axis_tready is high.
// ============================================================================
`default_nettype none

module gwbm_result_bank (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 load,
    input  wire gwbm_pkg::cand_t                      cand,
    output logic                                      bank_free,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [gwbm_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                      m_axis_tlast
);

    localparam int NS = gwbm_pkg::NUM_SLOTS;

    logic [NS-1:0]                 mask_reg;
    logic [NS-1:0]                 mask_next;
    logic [NS-1:0]                 mask_rest;
    gwbm_pkg::slot_t [NS-1:0]      slot_reg;
    gwbm_pkg::slot_t               cur;
    logic [$clog2(NS)-1:0]         sel;
    logic                          out_fire;

    // lowest pending slot goes first
    always_comb
    begin
        if (mask_reg[0])
        begin
            sel = 2'd0;
        end
        else if (mask_reg[1])
        begin
            sel = 2'd1;
        end
        else if (mask_reg[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
    end

    assign cur       = slot_reg[sel];
    assign mask_rest = mask_reg & (mask_reg - NS'(1));
    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign bank_free = (mask_reg == '0) || ((mask_rest == '0) && m_axis_tready);

    always_comb
    begin
        if (load)
        begin
            mask_next = cand.valid;
        end
        else if (out_fire)
        begin
            mask_next = mask_rest;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= cand.slot;
        end
    end

    assign m_axis_tvalid = |mask_reg;
    assign m_axis_tdata  = {{gwbm_pkg::OUT_PAD_W{1'b0}}, cur.row_index, cur.column, cur.tile};
    assign m_axis_tlast  = cur.last;

    // the final tile is always the last slot of the final load
    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (mask_reg == 4'b1000))
        else $error("frame end sent before earlier slots");

    // each sent request retires exactly one slot
    a_retire: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !load) |=> ($countones(mask_reg) == $countones($past(mask_reg)) - 1))
        else $error("result slot lost or repeated");

endmodule

`default_nettype wire
